// ----- sv/displacement_outlier_filter_macros.svh -----
// Assertion macros shared by the checker of the displacement outlier filter.
// Depends on signals named clk and rst_n in the scope that uses them.
`ifndef DISPLACEMENT_OUTLIER_FILTER_MACROS_SVH
`define DISPLACEMENT_OUTLIER_FILTER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DOF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define DOF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- sv/dof_pkg.sv -----
// Shared types, constants and the arctangent table of the displacement outlier filter.
// No dependencies.
package dof_pkg;

  localparam int COORD_W = 17;
  localparam int DIFF_W  = 18;
  localparam int CW      = 34;
  localparam int N_W     = 7;

  localparam logic REG_K_SIGMA   = 1'b0;
  localparam logic REG_MAX_ANGLE = 1'b1;

  typedef struct packed {
    logic [COORD_W-1:0]       sx;
    logic [COORD_W-1:0]       sy;
    logic [COORD_W-1:0]       dxp;
    logic [COORD_W-1:0]       dyp;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic                     store;
    logic                     last;
  } item_t;

  typedef struct packed {
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
    logic [COORD_W-1:0] dxp;
    logic [COORD_W-1:0] dyp;
    logic [5:0]         idx;
    logic               none;
    logic               last;
  } result_t;

  typedef struct packed {
    logic               vec;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cordic_in_t;

  typedef struct packed {
    logic               done;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cordic_out_t;

  function automatic logic [31:0] atan_unit(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10680862;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- sv/dof_front.sv -----
// Input side: accepts point pairs, forms their offsets and marks which are stored.
// Depends on dof_pkg.
module dof_front #(
  parameter int MAX_PAIRS = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [dof_pkg::COORD_W-1:0] in_src_x,
  input  logic [dof_pkg::COORD_W-1:0] in_src_y,
  input  logic [dof_pkg::COORD_W-1:0] in_dst_x,
  input  logic [dof_pkg::COORD_W-1:0] in_dst_y,
  input  logic                        in_last_pair,
  input  logic                        q_full,
  output logic                        q_push,
  output dof_pkg::item_t              q_item
);
  localparam int CNT_W = $clog2(MAX_PAIRS + 1);

  logic [CNT_W-1:0] cnt_r;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    q_item.sx    = in_src_x;
    q_item.sy    = in_src_y;
    q_item.dxp   = in_dst_x;
    q_item.dyp   = in_dst_y;
    q_item.dx    = $signed({1'b0, in_dst_x}) - $signed({1'b0, in_src_x});
    q_item.dy    = $signed({1'b0, in_dst_y}) - $signed({1'b0, in_src_y});
    q_item.store = (cnt_r < CNT_W'(MAX_PAIRS));
    q_item.last  = in_last_pair;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (q_push) begin
      if (in_last_pair) begin
        cnt_r <= '0;
      end else if (q_item.store) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end
endmodule

// ----- sv/dof_queue.sv -----
// Two-entry queue of classified pairs between the input side and the processing side.
// Depends on dof_pkg.
module dof_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dof_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output dof_pkg::item_t pop_item,
  output logic           empty
);
  dof_pkg::item_t mem_r [2];
  logic           wp_r;
  logic           rp_r;
  logic [1:0]     cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_item = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ----- sv/dof_cordic.sv -----
// Iterative CORDIC unit, one micro-rotation per cycle, in vectoring or rotation mode.
// Depends on dof_pkg.
module dof_cordic #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  dof_pkg::cordic_in_t  cin,
  output dof_pkg::cordic_out_t cout
);
  localparam int STEP_W = $clog2(CORDIC_STEPS);

  logic signed [dof_pkg::CW-1:0] x_r, y_r, z_r;
  logic                          vec_r;
  logic [STEP_W-1:0]             i_r;
  logic                          busy_r;
  logic                          done_r;
  logic signed [dof_pkg::CW-1:0] xs, ys, au;
  logic                          sel;

  always_comb begin
    xs  = x_r >>> i_r;
    ys  = y_r >>> i_r;
    au  = $signed({2'b00, dof_pkg::atan_unit(5'(i_r))});
    sel = vec_r ? !y_r[dof_pkg::CW-1] : z_r[dof_pkg::CW-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      i_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        x_r    <= cin.x;
        y_r    <= cin.y;
        z_r    <= cin.z;
        vec_r  <= cin.vec;
        i_r    <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (sel) begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + au;
        end else begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - au;
        end
        i_r <= i_r + 1'b1;
        if (i_r == STEP_W'(CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign cout.done = done_r;
  assign cout.x    = x_r;
  assign cout.y    = y_r;
  assign cout.z    = z_r;
endmodule

// ----- sv/dof_back.sv -----
// Processing side: direction and statistics per pair, then the filtering pass over the store.
// Depends on dof_pkg and dof_cordic.
module dof_back #(
  parameter int MAX_PAIRS    = 64,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [11:0]                 k_sigma,
  input  logic [15:0]                 max_angle_dev,
  input  logic                        q_empty,
  input  dof_pkg::item_t              q_item,
  output logic                        q_pop,
  input  logic                        out_ready,
  output logic                        out_valid,
  output dof_pkg::result_t            out_res
);
  localparam int CNT_W = $clog2(MAX_PAIRS + 1);
  localparam int IDX_W = $clog2(MAX_PAIRS);
  localparam int MEM_W = 4 * dof_pkg::COORD_W + 16;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_VEC   = 4'd1;
  localparam logic [3:0] ST_ROT   = 4'd2;
  localparam logic [3:0] ST_ACC   = 4'd3;
  localparam logic [3:0] ST_MEAN  = 4'd4;
  localparam logic [3:0] ST_MWAIT = 4'd5;
  localparam logic [3:0] ST_S1    = 4'd6;
  localparam logic [3:0] ST_S2    = 4'd7;
  localparam logic [3:0] ST_S3    = 4'd8;
  localparam logic [3:0] ST_S4    = 4'd9;
  localparam logic [3:0] ST_RD    = 4'd10;
  localparam logic [3:0] ST_E1    = 4'd11;
  localparam logic [3:0] ST_E2    = 4'd12;
  localparam logic [3:0] ST_E3    = 4'd13;
  localparam logic [3:0] ST_DEC   = 4'd14;
  localparam logic [3:0] ST_FLUSH = 4'd15;

  typedef logic signed [dof_pkg::CW-1:0] cw_t;

  function automatic dof_pkg::cordic_in_t vec_prep(input cw_t x, input cw_t y);
    dof_pkg::cordic_in_t r;
    r.vec = 1'b1;
    if (x < 0) begin
      r.x = -x;
      r.y = -y;
      r.z = cw_t'(34'sh0_8000_0000);
    end else begin
      r.x = x;
      r.y = y;
      r.z = '0;
    end
    return r;
  endfunction

  function automatic logic [15:0] round_angle(input cw_t z);
    logic [31:0] t;
    t = z[31:0] + 32'h0000_8000;
    return t[31:16];
  endfunction

  function automatic logic signed [15:0] to_q15(input cw_t v, input logic neg);
    logic signed [34:0] t;
    logic signed [19:0] r;
    logic signed [15:0] q;
    t = {v[dof_pkg::CW-1], v} + 35'sd16384;
    r = t[34:15];
    if (neg) begin
      r = -r;
    end
    if (r > 20'sd32767) begin
      q = 16'sd32767;
    end else if (r < -20'sd32768) begin
      q = -16'sd32768;
    end else begin
      q = r[15:0];
    end
    return q;
  endfunction

  function automatic logic [dof_pkg::N_W-1:0] N_X(input logic [CNT_W-1:0] n);
    return dof_pkg::N_W'(n);
  endfunction

  logic [3:0]               state_r;
  dof_pkg::item_t           item_r;
  logic                     zv_r;
  logic                     neg_r;
  logic                     start_r;
  dof_pkg::cordic_in_t      cin_r;
  dof_pkg::cordic_out_t     cout;
  logic [15:0]              angle_r;
  logic [15:0]              mean_r;
  logic signed [15:0]       cos_r, sin_r;
  logic [CNT_W-1:0]         n_r;
  logic [CNT_W-1:0]         i_r;
  logic signed [23:0]       sum_dx_r, sum_dy_r;
  logic [41:0]              sum_sq_dx_r, sum_sq_dy_r;
  logic signed [21:0]       sum_cos_r, sum_sin_r;
  logic [48:0]              nq_x_r, nq_y_r;
  logic [47:0]              s2_x_r, s2_y_r;
  logic [23:0]              kk_r;
  logic [48:0]              v_x_r, v_y_r;
  logic [48:0]              plo_x_r, plo_y_r;
  logic [47:0]              phi_x_r, phi_y_r;
  logic [72:0]              rhs_x_r, rhs_y_r;
  logic [MEM_W-1:0]         mem [MAX_PAIRS];
  logic [MEM_W-1:0]         rd_q;
  logic signed [25:0]       px_r, py_r;
  logic [26:0]              ax_r, ay_r;
  logic [53:0]              e2x_r, e2y_r;
  logic [16:0]              da_r;
  dof_pkg::result_t         pend_r;
  logic                     pend_v_r;
  logic                     out_valid_r;
  dof_pkg::result_t         out_res_r;

  logic [15:0]              new_angle;
  logic [31:0]              rot_u;
  cw_t                      rot_z;
  dof_pkg::cordic_in_t      rot_in;
  logic                     rot_neg;
  logic [dof_pkg::COORD_W-1:0] m_sx, m_sy, m_dxp, m_dyp;
  logic [15:0]              m_ang;
  logic signed [dof_pkg::DIFF_W-1:0] m_dx, m_dy;
  logic [15:0]              m_da;
  logic [23:0]              abs_sx, abs_sy;
  logic signed [26:0]       ex, ey;
  logic                     keep;
  logic                     out_free;
  logic                     push;
  dof_pkg::result_t         push_res;
  dof_pkg::result_t         cur_res;

  dof_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r),
    .cin   (cin_r),
    .cout  (cout)
  );

  always_comb begin
    new_angle  = zv_r ? 16'd0 : round_angle(cout.z);
    rot_u      = {new_angle, 16'h0000};
    rot_z      = cw_t'($signed(rot_u));
    rot_neg    = 1'b0;
    if (rot_z > 34'sd1073741824) begin
      rot_z   = rot_z - 34'sd2147483648;
      rot_neg = 1'b1;
    end else if (rot_z < -34'sd1073741824) begin
      rot_z   = rot_z + 34'sd2147483648;
      rot_neg = 1'b1;
    end
    rot_in.vec = 1'b0;
    rot_in.x   = 34'sd652032874;
    rot_in.y   = '0;
    rot_in.z   = rot_z;
  end

  always_comb begin
    m_sx  = rd_q[16:0];
    m_sy  = rd_q[33:17];
    m_dxp = rd_q[50:34];
    m_dyp = rd_q[67:51];
    m_ang = rd_q[83:68];
    m_dx  = $signed({1'b0, m_dxp}) - $signed({1'b0, m_sx});
    m_dy  = $signed({1'b0, m_dyp}) - $signed({1'b0, m_sy});
    m_da  = m_ang - mean_r;
    abs_sx = sum_dx_r[23] ? 24'(-sum_dx_r) : 24'(sum_dx_r);
    abs_sy = sum_dy_r[23] ? 24'(-sum_dy_r) : 24'(sum_dy_r);
    ex = 27'(px_r) - 27'(sum_dx_r);
    ey = 27'(py_r) - 27'(sum_dy_r);
    keep = ({3'b000, e2x_r, 16'h0000} <= rhs_x_r) &&
           ({3'b000, e2y_r, 16'h0000} <= rhs_y_r) &&
           (da_r <= {1'b0, max_angle_dev});
    cur_res.sx   = m_sx;
    cur_res.sy   = m_sy;
    cur_res.dxp  = m_dxp;
    cur_res.dyp  = m_dyp;
    cur_res.idx  = 6'(i_r);
    cur_res.none = 1'b0;
    cur_res.last = 1'b0;
  end

  always_comb begin
    out_free = !out_valid_r || out_ready;
    push     = 1'b0;
    push_res = pend_r;
    if (state_r == ST_DEC) begin
      push     = keep && pend_v_r && out_free;
      push_res = pend_r;
    end else if (state_r == ST_FLUSH) begin
      push = out_free;
      if (pend_v_r) begin
        push_res      = pend_r;
        push_res.last = 1'b1;
      end else begin
        push_res      = '0;
        push_res.none = 1'b1;
        push_res.last = 1'b1;
      end
    end
  end

  assign q_pop     = (state_r == ST_IDLE) && !q_empty;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_ff @(posedge clk) begin
    if (state_r == ST_ACC) begin
      mem[n_r[IDX_W-1:0]] <= {angle_r, item_r.dyp, item_r.dxp, item_r.sy, item_r.sx};
    end
    if (state_r == ST_RD) begin
      rd_q <= mem[i_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_res_r <= push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      start_r     <= 1'b0;
      n_r         <= '0;
      i_r         <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      sum_dx_r    <= '0;
      sum_dy_r    <= '0;
      sum_sq_dx_r <= '0;
      sum_sq_dy_r <= '0;
      sum_cos_r   <= '0;
      sum_sin_r   <= '0;
    end else begin
      start_r <= 1'b0;
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (!q_empty) begin
            item_r <= q_item;
            if (q_item.store) begin
              cin_r   <= vec_prep(cw_t'(q_item.dx), cw_t'(q_item.dy));
              zv_r    <= (q_item.dx == '0) && (q_item.dy == '0);
              start_r <= 1'b1;
              state_r <= ST_VEC;
            end else if (q_item.last) begin
              state_r <= ST_MEAN;
            end
          end
        end
        ST_VEC: begin
          if (cout.done) begin
            angle_r <= new_angle;
            cin_r   <= rot_in;
            neg_r   <= rot_neg;
            start_r <= 1'b1;
            state_r <= ST_ROT;
          end
        end
        ST_ROT: begin
          if (cout.done) begin
            cos_r   <= to_q15(cout.x, neg_r);
            sin_r   <= to_q15(cout.y, neg_r);
            state_r <= ST_ACC;
          end
        end
        ST_ACC: begin
          sum_dx_r    <= sum_dx_r + 24'(item_r.dx);
          sum_dy_r    <= sum_dy_r + 24'(item_r.dy);
          sum_sq_dx_r <= sum_sq_dx_r +
                         42'(unsigned'(36'(item_r.dx) * 36'(item_r.dx)));
          sum_sq_dy_r <= sum_sq_dy_r +
                         42'(unsigned'(36'(item_r.dy) * 36'(item_r.dy)));
          sum_cos_r   <= sum_cos_r + 22'(cos_r);
          sum_sin_r   <= sum_sin_r + 22'(sin_r);
          n_r         <= n_r + 1'b1;
          state_r     <= item_r.last ? ST_MEAN : ST_IDLE;
        end
        ST_MEAN: begin
          cin_r   <= vec_prep(cw_t'(sum_cos_r), cw_t'(sum_sin_r));
          zv_r    <= (sum_cos_r == '0) && (sum_sin_r == '0);
          start_r <= 1'b1;
          state_r <= ST_MWAIT;
        end
        ST_MWAIT: begin
          if (cout.done) begin
            mean_r  <= new_angle;
            state_r <= ST_S1;
          end
        end
        ST_S1: begin
          nq_x_r  <= 49'(N_X(n_r)) * 49'(sum_sq_dx_r);
          nq_y_r  <= 49'(N_X(n_r)) * 49'(sum_sq_dy_r);
          s2_x_r  <= 48'(abs_sx) * 48'(abs_sx);
          s2_y_r  <= 48'(abs_sy) * 48'(abs_sy);
          kk_r    <= 24'(k_sigma) * 24'(k_sigma);
          state_r <= ST_S2;
        end
        ST_S2: begin
          v_x_r   <= (nq_x_r >= 49'(s2_x_r)) ? nq_x_r - 49'(s2_x_r) : '0;
          v_y_r   <= (nq_y_r >= 49'(s2_y_r)) ? nq_y_r - 49'(s2_y_r) : '0;
          state_r <= ST_S3;
        end
        ST_S3: begin
          plo_x_r <= 49'(kk_r) * 49'(v_x_r[24:0]);
          plo_y_r <= 49'(kk_r) * 49'(v_y_r[24:0]);
          phi_x_r <= 48'(kk_r) * 48'(v_x_r[48:25]);
          phi_y_r <= 48'(kk_r) * 48'(v_y_r[48:25]);
          state_r <= ST_S4;
        end
        ST_S4: begin
          rhs_x_r <= {phi_x_r, 25'd0} + 73'(plo_x_r);
          rhs_y_r <= {phi_y_r, 25'd0} + 73'(plo_y_r);
          i_r     <= '0;
          state_r <= ST_RD;
        end
        ST_RD: begin
          state_r <= (i_r == n_r) ? ST_FLUSH : ST_E1;
        end
        ST_E1: begin
          px_r    <= $signed({1'b0, N_X(n_r)}) * m_dx;
          py_r    <= $signed({1'b0, N_X(n_r)}) * m_dy;
          da_r    <= m_da[15] ? 17'h10000 - {1'b0, m_da} : {1'b0, m_da};
          state_r <= ST_E2;
        end
        ST_E2: begin
          ax_r    <= ex[26] ? 27'(-ex) : 27'(ex);
          ay_r    <= ey[26] ? 27'(-ey) : 27'(ey);
          state_r <= ST_E3;
        end
        ST_E3: begin
          e2x_r   <= 54'(ax_r) * 54'(ax_r);
          e2y_r   <= 54'(ay_r) * 54'(ay_r);
          state_r <= ST_DEC;
        end
        ST_DEC: begin
          if (!(keep && pend_v_r && !out_free)) begin
            if (keep) begin
              pend_r   <= cur_res;
              pend_v_r <= 1'b1;
            end
            i_r     <= i_r + 1'b1;
            state_r <= ST_RD;
          end
        end
        ST_FLUSH: begin
          if (out_free) begin
            pend_v_r    <= 1'b0;
            n_r         <= '0;
            sum_dx_r    <= '0;
            sum_dy_r    <= '0;
            sum_sq_dx_r <= '0;
            sum_sq_dy_r <= '0;
            sum_cos_r   <= '0;
            sum_sin_r   <= '0;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end
endmodule

// ----- sv/displacement_outlier_filter.sv -----
// Top level of the displacement outlier filter: configuration registers and channel wiring.
// Depends on dof_pkg, dof_front, dof_queue and dof_back (which holds dof_cordic).
//
//   Channel  Ports        Moves per transaction
//   input    in_*         one matched point pair and its last_pair mark
//   output   out_*        one kept pair, or the empty marker of a set
//   config   psel et al.  one register write or read
//
// A stored pair passes the shared CORDIC unit in vectoring and then in rotation mode, then the
// accumulators; a pair beyond the store skips the CORDIC unit and the accumulators.
// At the set's end the mean direction and the spread statistics are formed, then the pass
// reads the store one pair at a time through its single read port, and ST_FLUSH sends the final result.
// Reset is synchronous and leaves the store unwritten; no clearing pass is needed.
// The two-entry queue lets the input side accept while the pass stalls on out_ready.
module displacement_outlier_filter #(
  parameter int MAX_PAIRS    = 64,
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [16:0] in_src_x,
  input  logic [16:0] in_src_y,
  input  logic [16:0] in_dst_x,
  input  logic [16:0] in_dst_y,
  input  logic        in_last_pair,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [16:0] out_src_x,
  output logic [16:0] out_src_y,
  output logic [16:0] out_dst_x,
  output logic [16:0] out_dst_y,
  output logic [5:0]  out_pair_index,
  output logic        out_none_kept,
  output logic        out_last_result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [11:0]      k_sigma_r;
  logic [15:0]      max_angle_r;
  logic             q_full, q_push, q_pop, q_empty;
  dof_pkg::item_t   push_item, pop_item;
  dof_pkg::result_t res;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == dof_pkg::REG_MAX_ANGLE) ? {16'h0000, max_angle_r}
                                                       : {20'h00000, k_sigma_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_sigma_r   <= 12'd512;
      max_angle_r <= 16'd1820;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == dof_pkg::REG_K_SIGMA) begin
        k_sigma_r <= pwdata[11:0];
      end else begin
        max_angle_r <= pwdata[15:0];
      end
    end
  end

  dof_front #(.MAX_PAIRS(MAX_PAIRS)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_src_x     (in_src_x),
    .in_src_y     (in_src_y),
    .in_dst_x     (in_dst_x),
    .in_dst_y     (in_dst_y),
    .in_last_pair (in_last_pair),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (push_item)
  );

  dof_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .empty     (q_empty)
  );

  dof_back #(.MAX_PAIRS(MAX_PAIRS), .CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .k_sigma       (k_sigma_r),
    .max_angle_dev (max_angle_r),
    .q_empty       (q_empty),
    .q_item        (pop_item),
    .q_pop         (q_pop),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_res       (res)
  );

  assign out_src_x       = res.sx;
  assign out_src_y       = res.sy;
  assign out_dst_x       = res.dxp;
  assign out_dst_y       = res.dyp;
  assign out_pair_index  = res.idx;
  assign out_none_kept   = res.none;
  assign out_last_result = res.last;
endmodule

// ----- sv/dof_checker.sv -----
// Port-level checker for the displacement outlier filter, bound to the top level.
// Depends on displacement_outlier_filter_macros.svh.
`include "displacement_outlier_filter_macros.svh"

module dof_port_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [16:0] out_src_x,
  input logic [16:0] out_dst_y,
  input logic [5:0]  out_pair_index,
  input logic        out_none_kept,
  input logic        out_last_result
);
  `DOF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_pair_index))
  `DOF_ASSERT_NOW(a_idle_after_reset, $past(!rst_n), !out_valid)
  `DOF_ASSERT_NOW(a_marker_last, out_valid && out_none_kept, out_last_result)
  `DOF_ASSERT_NOW(a_marker_empty, out_valid && out_none_kept,
                  out_pair_index == 6'd0 && out_src_x == 17'd0 && out_dst_y == 17'd0)
endmodule

bind displacement_outlier_filter dof_port_checker u_dof_checker (.*);

// ----- tb/sv/dof_checker.sv -----
// Checker for the displacement outlier filter: follows the register port and both channels,
// predicts the kept pairs of each set and compares them with what the block sends.
// Depends on dof_pkg for the result structure and the arctangent table.
`timescale 1ns / 1ps

module dof_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [16:0] in_src_x,
  input  logic [16:0] in_src_y,
  input  logic [16:0] in_dst_x,
  input  logic [16:0] in_dst_y,
  input  logic        in_last_pair,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [16:0] out_src_x,
  input  logic [16:0] out_src_y,
  input  logic [16:0] out_dst_x,
  input  logic [16:0] out_dst_y,
  input  logic [5:0]  out_pair_index,
  input  logic        out_none_kept,
  input  logic        out_last_result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          pending
);
  localparam int STORE_DEPTH = 64;
  localparam int ROT_STEPS   = 16;

  bit [16:0] src_x_m [STORE_DEPTH];
  bit [16:0] src_y_m [STORE_DEPTH];
  bit [16:0] dst_x_m [STORE_DEPTH];
  bit [16:0] dst_y_m [STORE_DEPTH];
  bit [15:0] dir_m   [STORE_DEPTH];
  longint    acc_dx, acc_dy, acc_cos, acc_sin;
  longint    acc_sq_dx, acc_sq_dy;
  int        stored;
  bit [11:0] k_sigma_r;
  bit [15:0] angle_lim_r;
  dof_pkg::result_t kept_q[$];

  function automatic bit [15:0] direction_of(longint x, longint y);
    bit [31:0] z;
    bit [31:0] t;
    longint    xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 16'd0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h8000_0000;
    end
    for (int i = 0; i < ROT_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys;
        y -= xs;
        z += dof_pkg::atan_unit(5'(i));
      end else begin
        x -= ys;
        y += xs;
        z -= dof_pkg::atan_unit(5'(i));
      end
    end
    t = z + 32'h8000;
    return t[31:16];
  endfunction

  function automatic longint round_q15(longint v, bit neg);
    longint r;
    r = (v + 16384) >>> 15;
    if (neg) r = -r;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r;
  endfunction

  function automatic void unit_vector(bit [15:0] a, output longint c, output longint s);
    bit [31:0] u;
    longint    z, x, y, xs, ys;
    bit        neg;
    u = {a, 16'h0};
    z = longint'($signed(u));
    x = 652032874;
    y = 0;
    neg = 0;
    if (z > 64'sd1073741824) begin
      z -= 64'sd2147483648;
      neg = 1;
    end else if (z < -64'sd1073741824) begin
      z += 64'sd2147483648;
      neg = 1;
    end
    for (int i = 0; i < ROT_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys;
        y += xs;
        z -= longint'(dof_pkg::atan_unit(5'(i)));
      end else begin
        x += ys;
        y -= xs;
        z += longint'(dof_pkg::atan_unit(5'(i)));
      end
    end
    c = round_q15(x, neg);
    s = round_q15(y, neg);
  endfunction

  function automatic bit within_spread(longint d, longint n, longint s, longint q);
    longint     e;
    bit [63:0]  ae, e2, nq, as2, v;
    bit [127:0] lhs, rhs;
    e = n * d - s;
    ae = (e < 0) ? -e : e;
    e2 = ae * ae;
    nq = n * q;
    as2 = (s < 0) ? -s : s;
    as2 = as2 * as2;
    v = (nq >= as2) ? nq - as2 : 64'd0;
    lhs = {64'd0, e2} << 16;
    rhs = 128'(k_sigma_r) * 128'(k_sigma_r) * 128'(v);
    return lhs <= rhs;
  endfunction

  task automatic close_set();
    bit [15:0] mean_dir;
    bit [15:0] diff;
    int        dev;
    longint    dx, dy;
    dof_pkg::result_t r;
    dof_pkg::result_t set_q[$];
    mean_dir = direction_of(acc_cos, acc_sin);
    for (int i = 0; i < stored; i++) begin
      dx = longint'(dst_x_m[i]) - longint'(src_x_m[i]);
      dy = longint'(dst_y_m[i]) - longint'(src_y_m[i]);
      diff = dir_m[i] - mean_dir;
      dev = int'($signed(diff));
      if (dev < 0) dev = -dev;
      if (within_spread(dx, stored, acc_dx, acc_sq_dx) &&
          within_spread(dy, stored, acc_dy, acc_sq_dy) && dev <= int'(angle_lim_r)) begin
        r = '0;
        r.sx = src_x_m[i];
        r.sy = src_y_m[i];
        r.dxp = dst_x_m[i];
        r.dyp = dst_y_m[i];
        r.idx = 6'(i);
        set_q = {set_q, r};
      end
    end
    if (set_q.size() == 0) begin
      r = '0;
      r.none = 1;
      set_q = {set_q, r};
    end
    set_q[set_q.size()-1].last = 1;
    foreach (set_q[j]) kept_q = {kept_q, set_q[j]};
    acc_dx = 0; acc_dy = 0; acc_cos = 0; acc_sin = 0;
    acc_sq_dx = 0; acc_sq_dy = 0;
    stored = 0;
  endtask

  task automatic take_pair();
    longint dx, dy, c, s;
    bit [15:0] a;
    if (stored < STORE_DEPTH) begin
      dx = longint'(in_dst_x) - longint'(in_src_x);
      dy = longint'(in_dst_y) - longint'(in_src_y);
      a = direction_of(dx, dy);
      unit_vector(a, c, s);
      src_x_m[stored] = in_src_x;
      src_y_m[stored] = in_src_y;
      dst_x_m[stored] = in_dst_x;
      dst_y_m[stored] = in_dst_y;
      dir_m[stored] = a;
      acc_dx += dx;
      acc_dy += dy;
      acc_sq_dx += dx * dx;
      acc_sq_dy += dy * dy;
      acc_cos += c;
      acc_sin += s;
      stored++;
    end
    if (in_last_pair) close_set();
  endtask

  always @(posedge clk) begin
    dof_pkg::result_t got;
    dof_pkg::result_t want;
    if (!rst_n) begin
      acc_dx = 0; acc_dy = 0; acc_cos = 0; acc_sin = 0;
      acc_sq_dx = 0; acc_sq_dy = 0;
      stored = 0;
      k_sigma_r = 12'd512;
      angle_lim_r = 16'd1820;
      errors = 0;
      pending = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == 3'd0) k_sigma_r = pwdata[11:0];
        else if (paddr == 3'd4) angle_lim_r = pwdata[15:0];
      end
      if (out_valid && out_ready) begin
        got = {out_src_x, out_src_y, out_dst_x, out_dst_y, out_pair_index,
               out_none_kept, out_last_result};
        if (kept_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, got);
          errors = errors + 1;
        end else begin
          want = kept_q.pop_front();
          if (got !== want) begin
            $display("%0t: result mismatch, expected %p, actual %p", $time, want, got);
            errors = errors + 1;
          end
        end
      end
      if (in_valid && in_ready) take_pair();
      pending = kept_q.size();
    end
  end

endmodule

// ----- tb/sv/tb_displacement_outlier_filter.sv -----
// Top of the displacement outlier filter testbench: clock, reset, register writes and pair
// stimulus in sets, with random idling on both channels. Depends on dof_checker and the RTL.
`timescale 1ns / 1ps

module tb_displacement_outlier_filter;

  localparam int SETTLE = 400;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [16:0] in_src_x = 0, in_src_y = 0, in_dst_x = 0, in_dst_y = 0;
  logic        in_last_pair = 0;
  logic        out_valid;
  logic        out_ready = 1;
  logic [16:0] out_src_x, out_src_y, out_dst_x, out_dst_y;
  logic [5:0]  out_pair_index;
  logic        out_none_kept, out_last_result;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [2:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;
  int          errors, pending;
  int          port_errors = 0;
  int          sent = 0;
  bit          quiet = 0;

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  displacement_outlier_filter u_dut (.*);

  dof_checker u_chk (.*);

  initial begin
    #10ms;
    $display("tb_displacement_outlier_filter: FAIL");
    $finish;
  end

  always begin
    @(negedge clk);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      out_ready = 0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
      out_ready = 1;
    end
  end

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    psel = 1; penable = 0; pwrite = 1; paddr = addr; pwdata = value;
    @(negedge clk);
    penable = 1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    pwrite = 0; penable = 0;
    @(negedge clk);
    penable = 1;
    do @(posedge clk); while (!pready);
    if (prdata !== value) begin
      $display("%0t: register readback at %0d, expected %0d, actual %0d",
               $time, addr, value, prdata);
      port_errors++;
    end
    @(negedge clk);
    psel = 0; penable = 0;
  endtask

  task automatic set_limits(input int k, input int lim);
    wait (pending == 0);
    repeat (SETTLE) @(negedge clk);
    write_reg(3'd0, 32'(k));
    write_reg(3'd4, 32'(lim));
  endtask

  task automatic send_pair(input int sx, input int sy, input int dx, input int dy,
                           input bit last);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid = 0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_valid = 1;
    in_src_x = 17'(sx); in_src_y = 17'(sy); in_dst_x = 17'(dx); in_dst_y = 17'(dy);
    in_last_pair = last;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    sent++;
  endtask

  function automatic int clamp_coord(int v);
    return (v < 0) ? 0 : (v > 131071) ? 131071 : v;
  endfunction

  task automatic send_set(input int size, input int spread, input int outliers);
    int ox, oy, sx, sy, nx, ny;
    ox = $urandom_range(0, 8000) - 4000;
    oy = $urandom_range(0, 8000) - 4000;
    for (int i = 0; i < size; i++) begin
      sx = $urandom_range(0, 131071);
      sy = $urandom_range(0, 131071);
      if ($urandom_range(0, 99) < outliers) begin
        nx = $urandom_range(0, 131071);
        ny = $urandom_range(0, 131071);
      end else begin
        nx = clamp_coord(sx + ox + $urandom_range(0, 2 * spread) - spread);
        ny = clamp_coord(sy + oy + $urandom_range(0, 2 * spread) - spread);
      end
      send_pair(sx, sy, nx, ny, i == size - 1);
    end
    in_valid = 0;
  endtask

  initial begin
    int size;
    repeat (7) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    send_pair(0, 0, 131071, 131071, 1);
    send_pair(131071, 131071, 0, 0, 0);
    send_pair(131071, 0, 0, 131071, 0);
    send_pair(500, 500, 500, 500, 1);
    in_valid = 0;
    set_limits(0, 0);
    for (int i = 0; i < 4; i++) send_pair(1000, 2000, 1200, 1900, i == 3);
    send_pair(10, 10, 20, 30, 0);
    send_pair(50, 50, 60, 70, 0);
    send_pair(70, 90, 60, 70, 1);
    in_valid = 0;
    set_limits(4095, 32768);
    send_set(6, 50, 30);
    set_limits(256, 1820);
    send_set(5, 0, 0);

    set_limits(512, 4000);
    send_set(67, 200, 10);

    while (sent < 170) begin
      if ($urandom_range(0, 2) == 0)
        set_limits($urandom_range(0, 2) == 0 ? 4095 : $urandom_range(0, 1024),
                   $urandom_range(0, 3) == 0 ? 32768 : $urandom_range(0, 6000));
      if (sent > 140) quiet = 1;
      size = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 10);
      send_set(size, $urandom_range(0, 400), $urandom_range(0, 25));
    end

    wait (pending == 0);
    repeat (SETTLE) @(negedge clk);
    if (errors == 0 && port_errors == 0 && pending == 0)
      $display("tb_displacement_outlier_filter: PASS");
    else
      $display("tb_displacement_outlier_filter: FAIL");
    $finish;
  end

endmodule

// ----- displacement_outlier_filter.f -----
+incdir+sv
sv/dof_pkg.sv
sv/dof_front.sv
sv/dof_queue.sv
sv/dof_cordic.sv
sv/dof_back.sv
sv/displacement_outlier_filter.sv
sv/dof_checker.sv
tb/sv/dof_checker.sv
tb/sv/tb_displacement_outlier_filter.sv
